[hw/rtl/btha_pkg.sv]
package btha_pkg;

  typedef enum logic [1:0] {
    CmdAlloc = 2'd0,
    CmdFree  = 2'd1,
    CmdQuery = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] request_bytes;
    logic [12:0] alignment;
    logic [11:0] align_offset;
    logic [14:0] user_address;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [14:0] result_address;
    logic [14:0] block_bytes;
  } rsp_t;

  localparam logic [63:0] InUseBit  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SizeMask  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] TagBytes  = 64'd16;
  localparam logic [63:0] WordBytes = 64'd8;

endpackage

[hw/rtl/boundary_tag_heap_allocator_top.sv]
// throughput: one item at a time; the next item is taken the cycle after the result leaves
// each heap access is one read or one write on a 64-bit memory, used one access at a time, registered read
// reset: control clears at once, then a clearing pass writes all HEAP_WORDS words (zero, but a
// free header in word 0), one a cycle, while no item is accepted
module boundary_tag_heap_allocator_top #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  btha_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output btha_pkg::rsp_t  out_data_o
);
  import btha_pkg::*;

  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam logic [63:0] HeapEnd = 64'(HEAP_WORDS) * 64'd8;
  localparam logic [AW:0] LastWord = (AW+1)'(HEAP_WORDS - 1);

  typedef enum logic [4:0] {
    SClear, SIdle, SRd, SWait, SAHdr, SAPut1, SAPut2, SAPut3, SAPut4, SABack,
    SFBp, SFHdr, SFNxt, SFNxtChk, SFPrv, SFPrvHdr, SFPrvChk, SQBp, SQHdr, SResp
  } state_e;

  logic [63:0] mem_q [HEAP_WORDS];
  logic [63:0] rdata_q;
  logic        we;
  logic [63:0] waddr, wdata, raddr;
  logic        rd_en;

  state_e      state_q, ret_q;
  logic [AW:0] clr_q;
  req_t        req_q;
  logic [63:0] cur_q, size_q, pad_q, blk_q, prev_q, a_q, b_q;
  rsp_t        rsp_q;
  logic        ov_q;

  // memory, out-of-range words read zero and ignore writes
  always_ff @(posedge clk_i) begin
    if (we && (waddr[63:3] < 61'(HEAP_WORDS))) mem_q[waddr[AW+2:3]] <= wdata;
    if (rd_en) begin
      if (raddr[63:3] < 61'(HEAP_WORDS)) rdata_q <= mem_q[raddr[AW+2:3]];
      else rdata_q <= '0;
    end
  end

  logic [63:0] m_w, offs_w, base_w, res_w, padc_w;
  always_comb begin
    logic [63:0] al;
    al = {51'd0, req_q.alignment};
    if (al == 0) al = 64'd1;
    m_w    = al - 64'd1;
    offs_w = {52'd0, req_q.align_offset};
    padc_w = ((({49'd0, req_q.request_bytes}) + 64'd7) & ~64'd7) + al + offs_w + WordBytes;
    base_w = cur_q + WordBytes;
    res_w  = ((base_w + offs_w + WordBytes + m_w) & ~m_w) - offs_w;
  end

  // memory port control per state
  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; rd_en = 1'b0; raddr = '0;
    case (state_q)
      SClear: begin
        we = 1'b1; waddr = {{(61-AW-1){1'b0}}, clr_q, 3'd0};
        wdata = (clr_q == 0) ? HeapEnd - TagBytes : '0;
      end
      SRd:    begin rd_en = 1'b1; raddr = a_q; end
      SAPut1: begin we = 1'b1; waddr = a_q; wdata = b_q; end
      SAPut2: begin we = 1'b1; waddr = a_q; wdata = b_q; end
      SAPut3: begin we = 1'b1; waddr = cur_q; wdata = pad_q | InUseBit; end
      SAPut4: begin we = 1'b1; waddr = cur_q + WordBytes + pad_q; wdata = cur_q; end
      SABack: begin we = 1'b1; waddr = res_w - WordBytes; wdata = base_w; end
      SFNxt:  begin we = 1'b1; waddr = a_q; wdata = b_q; end
      // while ret_q is still SFPrvChk this state only inspects the previous header
      SFPrvChk: if (ret_q != SFPrvChk) begin
        we = 1'b1; waddr = a_q; wdata = b_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; ret_q <= SIdle; clr_q <= '0; ov_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        SClear: begin
          if (clr_q == LastWord) state_q <= SIdle;
          clr_q <= clr_q + 1'b1;
        end
        SIdle: if (in_valid_i && !ov_q) begin
          req_q <= in_data_i; rsp_q <= '0; cur_q <= '0;
          case (in_data_i.command)
            CmdAlloc: begin a_q <= '0; ret_q <= SAHdr; state_q <= SRd; end
            CmdFree: begin
              a_q <= {49'd0, in_data_i.user_address} - WordBytes;
              ret_q <= SFBp; state_q <= SRd;
            end
            CmdQuery: begin
              a_q <= {49'd0, in_data_i.user_address} - WordBytes;
              ret_q <= SQBp; state_q <= SRd;
            end
            default: state_q <= SResp;
          endcase
        end
        SRd:   state_q <= SWait;
        SWait: state_q <= ret_q;
        // first-fit walk
        SAHdr: begin
          size_q <= rdata_q & SizeMask;
          if (!rdata_q[63] && (rdata_q & SizeMask) >= padc_w) begin
            state_q <= SAPut1;
            if ((rdata_q & SizeMask) - padc_w <= TagBytes) pad_q <= rdata_q & SizeMask;
            else begin
              pad_q <= padc_w;
              a_q <= cur_q + TagBytes + padc_w;
              b_q <= ((rdata_q & SizeMask) - padc_w - TagBytes) & SizeMask;
            end
          end else if (cur_q + TagBytes + (rdata_q & SizeMask) < HeapEnd) begin
            cur_q <= cur_q + TagBytes + (rdata_q & SizeMask);
            a_q <= cur_q + TagBytes + (rdata_q & SizeMask);
            state_q <= SRd;
          end else begin
            rsp_q.status <= 1'b1; state_q <= SResp;
          end
        end
        SAPut1: begin
          if (pad_q == size_q) state_q <= SAPut3;
          else begin
            a_q <= a_q + WordBytes + b_q; b_q <= a_q; state_q <= SAPut2;
          end
        end
        SAPut2: state_q <= SAPut3;
        SAPut3: state_q <= SAPut4;
        SAPut4: state_q <= SABack;
        SABack: begin
          rsp_q.result_address <= res_w[14:0];
          rsp_q.block_bytes <= pad_q[14:0];
          state_q <= SResp;
        end
        // free: back pointer, header, then merges
        SFBp: begin
          blk_q <= rdata_q - WordBytes; a_q <= rdata_q - WordBytes;
          ret_q <= SFHdr; state_q <= SRd;
        end
        SFHdr: begin
          size_q <= rdata_q & SizeMask;
          a_q <= blk_q; b_q <= rdata_q & SizeMask;
          ret_q <= SFNxtChk; state_q <= SFNxt;
        end
        SFNxt: begin
          if (ret_q == SFNxtChk) begin
            a_q <= a_q + WordBytes + b_q; b_q <= blk_q; ret_q <= SFPrv;
          end else if (ret_q == SFPrv) begin
            if (blk_q + TagBytes + size_q < HeapEnd) begin
              a_q <= blk_q + TagBytes + size_q; ret_q <= SFNxtChk; state_q <= SRd;
            end else state_q <= SFPrv;
          end else if (ret_q == SFHdr) begin
            // merged header written, footer next
            a_q <= a_q + WordBytes + b_q; b_q <= blk_q; ret_q <= SIdle;
          end else begin
            state_q <= SFPrv;
          end
        end
        SFNxtChk: begin
          if (!rdata_q[63]) begin
            size_q <= (size_q + (rdata_q & SizeMask) + TagBytes) & SizeMask;
            a_q <= blk_q; b_q <= (size_q + (rdata_q & SizeMask) + TagBytes) & SizeMask;
            ret_q <= SFHdr; state_q <= SFNxt;
          end else state_q <= SFPrv;
        end
        SFPrv: begin
          if (blk_q != 0) begin
            a_q <= blk_q - WordBytes; ret_q <= SFPrvHdr; state_q <= SRd;
          end else state_q <= SResp;
        end
        SFPrvHdr: begin
          prev_q <= rdata_q; a_q <= rdata_q; ret_q <= SFPrvChk; state_q <= SRd;
        end
        SFPrvChk: begin
          if (ret_q == SFPrvChk) begin
            if (!rdata_q[63]) begin
              b_q <= ((size_q + (rdata_q & SizeMask) + TagBytes) & SizeMask);
              size_q <= ((size_q + (rdata_q & SizeMask) + TagBytes) & SizeMask);
              a_q <= prev_q; ret_q <= SFPrvHdr;
            end else state_q <= SResp;
          end else if (ret_q == SFPrvHdr) begin
            a_q <= prev_q + WordBytes + size_q; b_q <= prev_q; ret_q <= SResp;
          end else state_q <= SResp;
        end
        // query
        SQBp: begin a_q <= rdata_q - WordBytes; ret_q <= SQHdr; state_q <= SRd; end
        SQHdr: begin rsp_q.block_bytes <= rdata_q[14:0]; state_q <= SResp; end
        SResp: begin ov_q <= 1'b1; state_q <= SIdle; end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;
endmodule

[hw/rtl/btha_checker.sv]
module btha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input btha_pkg::rsp_t out_data_o
);
  import btha_pkg::*;

  // one item in flight: no accept while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");

  // result never appears right after an accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");

  // no-fit carries zero fields
  a_nofit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |->
      (out_data_o.result_address == 0 && out_data_o.block_bytes == 0))
    else $error("no-fit with data");
endmodule

bind boundary_tag_heap_allocator_top btha_checker u_btha_checker (.*);
